### design/para_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// para_pkg
// Shared widths, command and status codes, and controller/datapath link types
// for the per-address signal-strength accumulator.
// ----------------------------------------------------------------------------
package para_pkg;

    // Default table depth and the most results one dump can produce.
    localparam int ENTRIES_DEFAULT = 64;
    localparam int MAX_RESULTS     = 64;

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 48;
    localparam int RSSI_W   = 8;
    localparam int SUM_W    = 24;
    localparam int CNT_W    = 16;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Request command codes.
    localparam logic [CMD_W-1:0] CMD_OBSERVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP    = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_UPDATED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUMP_ENTRY = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUMP_EMPTY = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the accepted request payload
        logic rd_en;      // read the table at rd_addr
        logic hit;        // update the matched slot and capture it
        logic add;        // append a new entry at add_addr
        logic drop;       // capture a table-full report
        logic clear_rpt;  // capture a cleared report
        logic empty_rpt;  // capture an empty-dump report
        logic dump_cap;   // capture the slot just read for a dump
        logic last;       // last flag for a dump capture
        logic div_start;  // start averaging the captured slot
        logic emit;       // move the captured result into the output register
    } para_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;      // read data valid and address equal to the request
        logic rd_vld;     // a table read is returning this cycle
        logic div_done;   // average is ready
        logic out_free;   // output register can take a result
    } para_stat_t;

endpackage
`default_nettype wire

### design/para_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// para_req_if
// Request channel: valid/ready handshake carrying one command with its
// source address and signal strength.
// ----------------------------------------------------------------------------
interface para_req_if;
    logic                                valid;
    logic                                ready;
    logic [para_pkg::CMD_W-1:0]          cmd;
    logic [para_pkg::ADDR_W-1:0]         source_address;
    logic signed [para_pkg::RSSI_W-1:0]  signal_strength;

    modport source (
        output valid, cmd, source_address, signal_strength,
        input  ready
    );

    modport sink (
        input  valid, cmd, source_address, signal_strength,
        output ready
    );
endinterface
`default_nettype wire

### design/para_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// para_rsp_if
// Result channel: valid/ready handshake carrying one table report.
// ----------------------------------------------------------------------------
interface para_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [para_pkg::STATUS_W-1:0]       status;
    logic [para_pkg::INDEX_W-1:0]        entry_index;
    logic [para_pkg::ADDR_W-1:0]         reported_address;
    logic signed [para_pkg::RSSI_W-1:0]  average_strength;
    logic [para_pkg::CNT_W-1:0]          sample_count;
    logic                                last;

    modport source (
        output valid, status, entry_index, reported_address, average_strength,
               sample_count, last,
        input  ready
    );

    modport sink (
        input  valid, status, entry_index, reported_address, average_strength,
               sample_count, last,
        output ready
    );
endinterface
`default_nettype wire

### design/para_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// para_div
// Serial restoring divider: signed sum over unsigned count, truncated toward
// zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module para_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [para_pkg::SUM_W-1:0]  dividend,
    input  wire logic [para_pkg::CNT_W-1:0]         divisor,
    output logic                                    done,
    output logic signed [para_pkg::RSSI_W-1:0]      quotient
);
    localparam int SumW  = para_pkg::SUM_W;
    localparam int CntW  = para_pkg::CNT_W;
    localparam int StepW = $clog2(SumW);
    localparam int RSSI_LOW = para_pkg::RSSI_W - 1;

    logic              busy_reg;
    logic              done_reg;
    logic [StepW-1:0]  step_reg;
    logic [CntW:0]     rem_reg;
    logic [SumW-1:0]   quo_reg;
    logic              neg_reg;
    logic [CntW-1:0]   divisor_reg;

    logic [CntW:0]     rem_shift;
    logic              take;
    logic [CntW:0]     rem_next;
    logic [RSSI_LOW:0] q_mag;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_shift = {rem_reg[CntW-1:0], quo_reg[SumW-1]};
        take      = (rem_shift >= {1'b0, divisor_reg});
        rem_next  = take ? (rem_shift - {1'b0, divisor_reg}) : rem_shift;
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == StepW'(SumW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + StepW'(1);
            end
        end
    end

    // Working registers: magnitude of the dividend becomes the quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg     <= dividend[SumW-1];
            quo_reg     <= dividend[SumW-1] ? (~dividend + SumW'(1)) : dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SumW-2:0], take};
        end
    end

    // The quotient magnitude never exceeds 128, so the low byte carries it.
    assign q_mag    = quo_reg[RSSI_LOW:0];
    assign quotient = neg_reg ? (~q_mag + para_pkg::RSSI_W'(1)) : q_mag;
    assign done     = done_reg;

endmodule
`default_nettype wire

### design/para_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// para_dp
// Datapath: the address, sum and count tables, the search compare, the
// update adders, the averaging divider and the output register.
// ----------------------------------------------------------------------------
module para_dp #(
    parameter int ENTRIES = para_pkg::ENTRIES_DEFAULT,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire para_pkg::para_cmd_t                 cmd,
    input  wire logic [IDX_W-1:0]                    rd_addr,
    input  wire logic [IDX_W-1:0]                    add_addr,
    output para_pkg::para_stat_t                     stat,
    input  wire logic [para_pkg::ADDR_W-1:0]         req_address,
    input  wire logic signed [para_pkg::RSSI_W-1:0]  req_strength,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [para_pkg::STATUS_W-1:0]            out_status,
    output logic [para_pkg::INDEX_W-1:0]             out_index,
    output logic [para_pkg::ADDR_W-1:0]              out_address,
    output logic signed [para_pkg::RSSI_W-1:0]       out_average,
    output logic [para_pkg::CNT_W-1:0]               out_count,
    output logic                                     out_last
);
    localparam int AddrW = para_pkg::ADDR_W;
    localparam int SumW  = para_pkg::SUM_W;
    localparam int CntW  = para_pkg::CNT_W;
    localparam int RssiW = para_pkg::RSSI_W;
    localparam int IdxOW = para_pkg::INDEX_W;

    // Tables.
    logic [AddrW-1:0]        addr_mem [ENTRIES];
    logic signed [SumW-1:0]  sum_mem  [ENTRIES];
    logic [CntW-1:0]         cnt_mem  [ENTRIES];

    // Read port data and tag.
    logic [AddrW-1:0]        addr_q;
    logic signed [SumW-1:0]  sum_q;
    logic [CntW-1:0]         cnt_q;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    rd_vld_reg;

    // Latched request payload.
    logic [AddrW-1:0]        in_addr_reg;
    logic signed [RssiW-1:0] in_rssi_reg;

    // Captured result under construction.
    logic [para_pkg::STATUS_W-1:0] work_status_reg;
    logic [IDX_W-1:0]              work_idx_reg;
    logic [AddrW-1:0]              work_addr_reg;
    logic signed [SumW-1:0]        work_sum_reg;
    logic [CntW-1:0]               work_cnt_reg;
    logic signed [RssiW-1:0]       work_avg_reg;
    logic                          work_last_reg;

    logic                    out_valid_reg;

    // Update arithmetic and table write port.
    logic signed [SumW-1:0]  rssi_ext;
    logic                    sat;
    logic signed [SumW-1:0]  upd_sum;
    logic [CntW-1:0]         upd_cnt;
    logic                    we;
    logic [IDX_W-1:0]        wa;
    logic [AddrW-1:0]        wd_addr;
    logic signed [SumW-1:0]  wd_sum;
    logic [CntW-1:0]         wd_cnt;
    logic [IDX_W+IdxOW-1:0]  idx_wide;

    logic                    div_done;
    logic signed [RssiW-1:0] div_q;

    // Sample accumulation; a saturated count freezes both sum and count.
    always_comb
    begin
        rssi_ext = {{(SumW-RssiW){in_rssi_reg[RssiW-1]}}, in_rssi_reg};
        sat      = (cnt_q == para_pkg::CNT_MAX);
        upd_sum  = sat ? sum_q : (sum_q + rssi_ext);
        upd_cnt  = sat ? cnt_q : (cnt_q + CntW'(1));
    end

    // Write port shared by updates and appends.
    always_comb
    begin
        we      = (cmd.hit && !sat) || cmd.add;
        wa      = cmd.add ? add_addr : rd_idx_reg;
        wd_addr = cmd.add ? in_addr_reg : addr_q;
        wd_sum  = cmd.add ? rssi_ext : upd_sum;
        wd_cnt  = cmd.add ? CntW'(1) : upd_cnt;
    end

    // Table write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            addr_mem[wa] <= wd_addr;
            sum_mem[wa]  <= wd_sum;
            cnt_mem[wa]  <= wd_cnt;
        end
        if (cmd.rd_en)
        begin
            addr_q     <= addr_mem[rd_addr];
            sum_q      <= sum_mem[rd_addr];
            cnt_q      <= cnt_mem[rd_addr];
            rd_idx_reg <= rd_addr;
        end
    end

    // Read-return flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
        end
    end

    // Request payload latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_addr_reg <= req_address;
            in_rssi_reg <= req_strength;
        end
    end

    // Result capture for every kind of report.
    always_ff @(posedge clk)
    begin
        if (cmd.hit)
        begin
            work_status_reg <= para_pkg::ST_UPDATED;
            work_idx_reg    <= rd_idx_reg;
            work_addr_reg   <= addr_q;
            work_sum_reg    <= upd_sum;
            work_cnt_reg    <= upd_cnt;
            work_last_reg   <= 1'b1;
        end
        else if (cmd.add)
        begin
            work_status_reg <= para_pkg::ST_ADDED;
            work_idx_reg    <= add_addr;
            work_addr_reg   <= in_addr_reg;
            work_sum_reg    <= rssi_ext;
            work_cnt_reg    <= CntW'(1);
            work_avg_reg    <= in_rssi_reg;
            work_last_reg   <= 1'b1;
        end
        else if (cmd.drop || cmd.clear_rpt || cmd.empty_rpt)
        begin
            if (cmd.drop)
            begin
                work_status_reg <= para_pkg::ST_DROPPED;
                work_addr_reg   <= in_addr_reg;
            end
            else
            begin
                work_status_reg <= cmd.clear_rpt ? para_pkg::ST_CLEARED
                                                 : para_pkg::ST_DUMP_EMPTY;
                work_addr_reg   <= '0;
            end
            work_idx_reg  <= '0;
            work_sum_reg  <= '0;
            work_cnt_reg  <= '0;
            work_avg_reg  <= '0;
            work_last_reg <= 1'b1;
        end
        else if (cmd.dump_cap)
        begin
            work_status_reg <= para_pkg::ST_DUMP_ENTRY;
            work_idx_reg    <= rd_idx_reg;
            work_addr_reg   <= addr_q;
            work_sum_reg    <= sum_q;
            work_cnt_reg    <= cnt_q;
            work_last_reg   <= cmd.last;
        end
        else if (div_done)
        begin
            work_avg_reg <= div_q;
        end
    end

    // Averaging divider.
    para_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (work_sum_reg),
        .divisor  (work_cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Slot number reported modulo the index field width.
    assign idx_wide = {{IdxOW{1'b0}}, work_idx_reg};

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status  <= work_status_reg;
            out_index   <= idx_wide[IdxOW-1:0];
            out_address <= work_addr_reg;
            out_average <= work_avg_reg;
            out_count   <= work_cnt_reg;
            out_last    <= work_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign stat.match    = rd_vld_reg && (addr_q == in_addr_reg);
    assign stat.rd_vld   = rd_vld_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule
`default_nettype wire

### design/para_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// para_ctrl
// Controller: request decode, table search sequencing, fill count, dump
// walk and result hand-off.
// ----------------------------------------------------------------------------
module para_ctrl #(
    parameter int ENTRIES = para_pkg::ENTRIES_DEFAULT,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int USED_W  = $clog2(ENTRIES + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    input  wire logic [para_pkg::CMD_W-1:0]  req_cmd,
    output logic                             req_ready,
    input  wire para_pkg::para_stat_t        stat,
    output para_pkg::para_cmd_t              cmd,
    output logic [IDX_W-1:0]                 rd_addr,
    output logic [IDX_W-1:0]                 add_addr
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DRD,
        S_DCAP,
        S_DIVGO,
        S_DIVWAIT,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic [USED_W-1:0]  issue_reg, issue_next;
    logic [USED_W-1:0]  dump_idx_reg, dump_idx_next;
    logic               dump_reg, dump_next;

    logic [USED_W-1:0]  dump_lim;
    logic               dump_last;

    // A dump reports at most the result limit.
    assign dump_lim  = (ENTRIES > para_pkg::MAX_RESULTS &&
                        used_reg > USED_W'(para_pkg::MAX_RESULTS))
                       ? USED_W'(para_pkg::MAX_RESULTS) : used_reg;
    assign dump_last = ((dump_idx_reg + USED_W'(1)) == dump_lim);

    assign req_ready = (state_reg == S_IDLE);
    assign add_addr  = used_reg[IDX_W-1:0];
    assign rd_addr   = (state_reg == S_DRD) ? dump_idx_reg[IDX_W-1:0]
                                            : issue_reg[IDX_W-1:0];

    // Next-state and command decode.
    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        issue_next    = issue_reg;
        dump_idx_next = dump_idx_reg;
        dump_next     = dump_reg;
        cmd           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    case (req_cmd)
                        para_pkg::CMD_OBSERVE:
                        begin
                            issue_next = '0;
                            dump_next  = 1'b0;
                            state_next = S_SEARCH;
                        end
                        para_pkg::CMD_CLEAR:
                        begin
                            used_next     = '0;
                            cmd.clear_rpt = 1'b1;
                            dump_next     = 1'b0;
                            state_next    = S_EMIT;
                        end
                        para_pkg::CMD_DUMP:
                        begin
                            if (used_reg == '0)
                            begin
                                cmd.empty_rpt = 1'b1;
                                dump_next     = 1'b0;
                                state_next    = S_EMIT;
                            end
                            else
                            begin
                                dump_idx_next = '0;
                                dump_next     = 1'b1;
                                state_next    = S_DRD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // One slot read per cycle; the compare acts on the read data in the cycle after the read.
            S_SEARCH:
            begin
                if (stat.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_DIVGO;
                end
                else if (issue_reg != used_reg)
                begin
                    cmd.rd_en  = 1'b1;
                    issue_next = issue_reg + USED_W'(1);
                end
                else if (!stat.rd_vld)
                begin
                    if (used_reg < USED_W'(ENTRIES))
                    begin
                        cmd.add   = 1'b1;
                        used_next = used_reg + USED_W'(1);
                    end
                    else
                    begin
                        cmd.drop = 1'b1;
                    end
                    state_next = S_EMIT;
                end
            end

            S_DRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_DCAP;
            end

            S_DCAP:
            begin
                cmd.dump_cap = 1'b1;
                cmd.last     = dump_last;
                state_next   = S_DIVGO;
            end

            S_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVWAIT;
            end

            S_DIVWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_EMIT;
                end
            end

            // Hand the result over once the output register is free.
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (dump_reg && !dump_last)
                    begin
                        dump_idx_next = dump_idx_reg + USED_W'(1);
                        state_next    = S_DRD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            issue_reg    <= '0;
            dump_idx_reg <= '0;
            dump_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            issue_reg    <= issue_next;
            dump_idx_reg <= dump_idx_next;
            dump_reg     <= dump_next;
        end
    end

endmodule
`default_nettype wire

### design/per_address_rssi_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_address_rssi_accumulator
// Table of source addresses with running signal-strength sums and counts.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one request at a time: observe (search, then
//   update, append or drop), clear, or dump. Results leave on the rsp
//   channel through an output register; every request but the unused
//   command code gives at least one result, and the final one carries last.
//   Observe: the table search reads one slot per cycle from the single
//   table read port; an update then runs the serial 24-step divider, while
//   an append or a drop skips it. Clear and an empty dump go straight from
//   idle to the result hand-off. A dump walks the table one entry at a
//   time, reading, capturing and averaging each entry before handing it over.
//   req.ready is high only while the controller is idle; the next request can
//   be taken while the previous result still sits in the output register.
//   When the receiver stalls, the block holds the result and waits before
//   loading the next one. Reset empties the table at once (fill count to
//   zero) and drops any result in flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_address_rssi_accumulator #(
    parameter int ENTRIES = para_pkg::ENTRIES_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    para_req_if.sink   req,
    para_rsp_if.source rsp
);
    localparam int IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UsedW = $clog2(ENTRIES + 1);

    para_pkg::para_cmd_t   cmd;
    para_pkg::para_stat_t  stat;
    logic [IdxW-1:0]       rd_addr;
    logic [IdxW-1:0]       add_addr;
    logic                  req_ready;

    // Sequencing.
    para_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IdxW),
        .USED_W  (UsedW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .add_addr  (add_addr)
    );

    assign req.ready = req_ready;

    // Tables, arithmetic and output register.
    para_dp #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IdxW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .add_addr     (add_addr),
        .stat         (stat),
        .req_address  (req.source_address),
        .req_strength (req.signal_strength),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .out_status   (rsp.status),
        .out_index    (rsp.entry_index),
        .out_address  (rsp.reported_address),
        .out_average  (rsp.average_strength),
        .out_count    (rsp.sample_count),
        .out_last     (rsp.last)
    );

endmodule
`default_nettype wire
